// ===== hw/rtl/lhp_pkg.sv =====
// shared types and constants of the latency histogram
package lhp_pkg;

  localparam int unsigned TIME_W   = 64;
  localparam int unsigned CNT_W    = 64;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned STORED_W = 11;
  localparam int unsigned BW_W     = 32;

  // nearest-rank fractions
  localparam int unsigned P99_NUM  = 99;
  localparam int unsigned P99_DEN  = 100;
  localparam int unsigned P999_NUM = 999;
  localparam int unsigned P999_DEN = 1000;

  typedef enum logic [1:0] {
    OP_RECORD      = 2'd0,
    OP_QUERY       = 2'd1,
    OP_BUCKET_READ = 2'd2
  } op_t;

  typedef struct packed {
    logic                rejected;
    logic [TIME_W-1:0]   median_latency;
    logic [TIME_W-1:0]   high_latency;
    logic [TIME_W-1:0]   extreme_latency;
    logic [STORED_W-1:0] stored_samples;
    logic [CNT_W-1:0]    overflow_total;
    logic [CNT_W-1:0]    record_total;
    logic [CNT_W-1:0]    bucket_value;
  } res_t;

endpackage

// ===== hw/rtl/lhp_ifs.sv =====
// request and result channel interfaces

interface lhp_in_if;
  import lhp_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [TIME_W-1:0] received_time;
  logic [TIME_W-1:0] send_time;
  logic [IDX_W-1:0]  bucket_index;
  modport source (output valid, operation, received_time, send_time, bucket_index,
                  input ready);
  modport sink (input valid, operation, received_time, send_time, bucket_index,
                output ready);
endinterface

interface lhp_out_if;
  import lhp_pkg::*;
  logic                valid;
  logic                ready;
  logic                rejected;
  logic [TIME_W-1:0]   median_latency;
  logic [TIME_W-1:0]   high_latency;
  logic [TIME_W-1:0]   extreme_latency;
  logic [STORED_W-1:0] stored_samples;
  logic [CNT_W-1:0]    overflow_total;
  logic [CNT_W-1:0]    record_total;
  logic [CNT_W-1:0]    bucket_value;
  modport source (output valid, rejected, median_latency, high_latency, extreme_latency,
                  stored_samples, overflow_total, record_total, bucket_value,
                  input ready);
  modport sink (input valid, rejected, median_latency, high_latency, extreme_latency,
                stored_samples, overflow_total, record_total, bucket_value,
                output ready);
endinterface

// ===== hw/rtl/latency_histogram_percentiles.sv =====
// latency histogram with nearest-rank percentiles over a sample store
//
//  channel   dir  words
//  items     in   operation, received_time, send_time, bucket_index
//  results   out  one word per item: percentiles, counts, bucket value
//  cfg       in   bucket_width write (cfg_wr_en / cfg_wr_data)
//
// record: the quotient latency / width comes from the 64-step restoring divider
// query: two divider runs for the ranks, then a radix select over the stored samples,
//   one bit per pass, one sample store read per cycle; empty store: no select
// bucket read: a single bucket memory read; one item is worked on at a time
// after rst the bucket memory is swept to zero, all NUM_BUCKETS entries, no items taken
// a finished word sits in the output register while the next item is accepted
module latency_histogram_percentiles #(
  parameter int unsigned NUM_BUCKETS     = 1024,
  parameter int unsigned SAMPLE_CAPACITY = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  lhp_in_if.sink                    items,
  lhp_out_if.source                 results,
  input  logic                      cfg_wr_en,
  input  logic [lhp_pkg::BW_W-1:0]  cfg_wr_data
);
  import lhp_pkg::*;

  localparam int unsigned BAW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned SAW = (SAMPLE_CAPACITY > 1) ? $clog2(SAMPLE_CAPACITY) : 1;
  localparam int unsigned FW  = $clog2(SAMPLE_CAPACITY + 1);
  localparam int unsigned RW  = FW + 11;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_REC_DIV, S_REC_RD, S_REC_WR, S_BKT_RD,
    S_Q99, S_Q999, S_SCAN, S_DRAIN, S_BIT, S_DONE
  } state_t;

  state_t state;

  // configuration and counters
  logic [BW_W-1:0]  bucket_width;
  logic [CNT_W-1:0] overflow_cnt;
  logic [CNT_W-1:0] total_cnt;
  logic [FW-1:0]    fill;
  logic [BAW-1:0]   clr_addr;

  // memories
  logic [CNT_W-1:0]  bkt_mem [NUM_BUCKETS];
  logic [TIME_W-1:0] smp_mem [SAMPLE_CAPACITY];
  logic [BAW-1:0]    bkt_addr;
  logic              bkt_we;
  logic [CNT_W-1:0]  bkt_wdata;
  logic [CNT_W-1:0]  bkt_rdata;
  logic [SAW-1:0]    smp_addr;
  logic              smp_we;
  logic [TIME_W-1:0] smp_rdata;

  // shared serial divider
  logic [TIME_W-1:0] dq;
  logic [BW_W:0]     rem;
  logic [BW_W-1:0]   dvs;
  logic [5:0]        dstep;
  logic [BW_W:0]     rem_sh;
  logic              div_ge;

  // radix select, three ranks in parallel
  logic [TIME_W-1:0] pfx  [3];
  logic [FW-1:0]     kk   [3];
  logic [FW-1:0]     cnt  [3];
  logic [TIME_W-1:0] pfx_next [3];
  logic [FW-1:0]     kk_next  [3];
  logic [TIME_W-1:0] hmask;
  logic [TIME_W-1:0] bsel;
  logic [FW-1:0]     scan_idx;
  logic              d_vld;

  logic              accept;
  logic [TIME_W-1:0] lat;
  logic [FW:0]       n1;
  logic [RW-1:0]     n99;
  logic [RW-1:0]     n999;
  res_t              res;
  logic              out_valid;
  res_t              out_reg;

  assign accept = items.valid && items.ready;
  assign items.ready = (state == S_IDLE);
  assign lat = items.send_time - items.received_time;
  assign n1 = (FW+1)'(fill) + (FW+1)'(1);
  assign n99 = RW'(n1) * RW'(P99_NUM);
  assign n999 = RW'(n1) * RW'(P999_NUM);

  assign rem_sh = {rem[BW_W-1:0], dq[TIME_W-1]};
  assign div_ge = rem_sh >= {1'b0, dvs};

  // memory port selection
  always_comb begin
    bkt_addr  = clr_addr;
    bkt_we    = 1'b0;
    bkt_wdata = '0;
    case (state)
      S_CLEAR: begin
        bkt_we = 1'b1;
      end
      S_IDLE: begin
        bkt_addr = BAW'(items.bucket_index);
      end
      S_REC_RD: begin
        bkt_addr = dq[BAW-1:0];
      end
      S_REC_WR: begin
        bkt_addr  = dq[BAW-1:0];
        bkt_we    = 1'b1;
        bkt_wdata = bkt_rdata + CNT_W'(1);
      end
      default: begin
        bkt_addr = clr_addr;
      end
    endcase
  end

  assign smp_we = accept && (op_t'(items.operation) == OP_RECORD) &&
                  (items.send_time >= items.received_time) &&
                  (fill < FW'(SAMPLE_CAPACITY));
  assign smp_addr = (state == S_IDLE) ? fill[SAW-1:0] : scan_idx[SAW-1:0];

  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_addr] <= bkt_wdata;
    end
    bkt_rdata <= bkt_mem[bkt_addr];
  end

  always_ff @(posedge clk) begin
    if (smp_we) begin
      smp_mem[smp_addr] <= lat;
    end
    smp_rdata <= smp_mem[smp_addr];
  end

  // end-of-bit decision for each rank
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (kk[r] < cnt[r]) begin
        pfx_next[r] = pfx[r];
        kk_next[r]  = kk[r];
      end else begin
        pfx_next[r] = pfx[r] | bsel;
        kk_next[r]  = kk[r] - cnt[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      bucket_width <= BW_W'(5000);
      overflow_cnt <= '0;
      total_cnt    <= '0;
      fill         <= '0;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
      d_vld        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bucket_width <= cfg_wr_data;
      end
      if (results.ready) begin
        out_valid <= 1'b0;
      end

      // a sample read issued last cycle lands now
      d_vld <= (state == S_SCAN);
      if (d_vld) begin
        for (int r = 0; r < 3; r++) begin
          if ((((smp_rdata ^ pfx[r]) & hmask) == '0) && ((smp_rdata & bsel) == '0)) begin
            cnt[r] <= cnt[r] + FW'(1);
          end
        end
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + BAW'(1);
          if (clr_addr == BAW'(NUM_BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res   <= '0;
            dstep <= '0;
            rem   <= '0;
            case (op_t'(items.operation))
              OP_RECORD: begin
                if (items.send_time < items.received_time) begin
                  res.rejected <= 1'b1;
                  state        <= S_DONE;
                end else begin
                  total_cnt <= total_cnt + CNT_W'(1);
                  if (smp_we) begin
                    fill <= fill + FW'(1);
                  end
                  dq    <= lat;
                  dvs   <= bucket_width;
                  state <= S_REC_DIV;
                end
              end
              OP_QUERY: begin
                if (fill == '0) begin
                  state <= S_DONE;
                end else begin
                  kk[0] <= FW'(n1 >> 1) - FW'(1);
                  dq    <= TIME_W'(n99);
                  dvs   <= BW_W'(P99_DEN);
                  state <= S_Q99;
                end
              end
              OP_BUCKET_READ: begin
                if (32'(items.bucket_index) < NUM_BUCKETS) begin
                  state <= S_BKT_RD;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_REC_DIV, S_Q99, S_Q999: begin
          rem   <= div_ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
          dq    <= {dq[TIME_W-2:0], div_ge};
          dstep <= dstep + 6'd1;
          if (dstep == 6'd63) begin
            dstep <= '0;
            rem   <= '0;
            case (state)
              S_REC_DIV: begin
                // quotient is complete in {dq[62:0], div_ge}
                if ((bucket_width == '0) ||
                    ({dq[TIME_W-2:0], div_ge} >= TIME_W'(NUM_BUCKETS))) begin
                  overflow_cnt <= overflow_cnt + CNT_W'(1);
                  state        <= S_DONE;
                end else begin
                  state <= S_REC_RD;
                end
              end
              S_Q99: begin
                kk[1] <= FW'({dq[TIME_W-2:0], div_ge} - TIME_W'(1));
                dq    <= TIME_W'(n999);
                dvs   <= BW_W'(P999_DEN);
                state <= S_Q999;
              end
              default: begin
                kk[2] <= FW'({dq[TIME_W-2:0], div_ge} - TIME_W'(1));
                for (int r = 0; r < 3; r++) begin
                  pfx[r] <= '0;
                  cnt[r] <= '0;
                end
                hmask    <= '0;
                bsel     <= {1'b1, {(TIME_W-1){1'b0}}};
                scan_idx <= '0;
                state    <= S_SCAN;
              end
            endcase
          end
        end
        S_REC_RD: begin
          state <= S_REC_WR;
        end
        S_REC_WR: begin
          state <= S_DONE;
        end
        S_BKT_RD: begin
          res.bucket_value <= bkt_rdata;
          state            <= S_DONE;
        end
        S_SCAN: begin
          scan_idx <= scan_idx + FW'(1);
          if (scan_idx == fill - FW'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_BIT;
        end
        S_BIT: begin
          for (int r = 0; r < 3; r++) begin
            pfx[r] <= pfx_next[r];
            kk[r]  <= kk_next[r];
            cnt[r] <= '0;
          end
          hmask    <= hmask | bsel;
          bsel     <= bsel >> 1;
          scan_idx <= '0;
          if (bsel[0]) begin
            res.median_latency  <= pfx_next[0];
            res.high_latency    <= pfx_next[1];
            res.extreme_latency <= pfx_next[2];
            res.stored_samples  <= STORED_W'(fill);
            res.overflow_total  <= overflow_cnt;
            state               <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_DONE: begin
          if (!out_valid || results.ready) begin
            out_reg              <= res;
            out_reg.record_total <= total_cnt;
            out_valid            <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign results.valid           = out_valid;
  assign results.rejected        = out_reg.rejected;
  assign results.median_latency  = out_reg.median_latency;
  assign results.high_latency    = out_reg.high_latency;
  assign results.extreme_latency = out_reg.extreme_latency;
  assign results.stored_samples  = out_reg.stored_samples;
  assign results.overflow_total  = out_reg.overflow_total;
  assign results.record_total    = out_reg.record_total;
  assign results.bucket_value    = out_reg.bucket_value;

endmodule

// ===== tb/tb_latency_histogram_percentiles.sv =====
// self-checking testbench for the latency histogram with nearest-rank percentiles
module tb_latency_histogram_percentiles;
  timeunit 1ns;
  timeprecision 1ps;
  import lhp_pkg::*;

  localparam int unsigned BUCKETS  = 1024;
  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned PHASE_ITEMS = 188;
  localparam longint unsigned CYCLE_LIMIT = 4000000;
  localparam longint unsigned ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // one row of the directed table: either a width write or an item
  typedef struct {
    bit        wr_width;
    bit [31:0] width_val;
    bit [1:0]  op;
    bit [63:0] recv;
    bit [63:0] send;
    bit [9:0]  idx;
    bit        fixed;
    res_t      want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en;
  logic [BW_W-1:0] cfg_wr_data;

  lhp_in_if  items_if ();
  lhp_out_if results_if ();

  latency_histogram_percentiles DUT (
    .clk         (clk),
    .rst         (rst),
    .items       (items_if),
    .results     (results_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the histogram state, updated as words are accepted
  longint unsigned bin_count [BUCKETS];
  longint unsigned overflow_cnt;
  longint unsigned record_cnt;
  longint unsigned latency_store [$];
  bit [31:0]       cur_width;

  res_t       pending_results [$];
  step_row_t  step_table [$];
  int         errors;
  longint unsigned cycles;
  bit         calm;          // stretch with no idling on either side
  int         n_records, n_rejects, n_queries, n_reads, last_bin;

  // nearest-rank pick over an ascending list, rank = ceil(n*num/den)
  function automatic longint unsigned rank_pick(ref longint unsigned srt [$],
                                                input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned n, rank;
    n = srt.size();
    rank = (n * num + den - 1) / den;
    if (rank < 1) rank = 1;
    if (rank > n) rank = n;
    return srt[rank - 1];
  endfunction

  // expected word for one accepted item; updates the shadow state
  function automatic res_t histogram_result(bit [1:0] op, bit [63:0] recv,
                                            bit [63:0] send, bit [9:0] idx);
    res_t r;
    longint unsigned lat, bin;
    longint unsigned srt [$];
    r = '0;
    case (op)
      OP_RECORD: begin
        if (send < recv) begin
          r.rejected = 1'b1;
        end else begin
          lat = send - recv;
          record_cnt++;
          if (cur_width == 0) begin
            overflow_cnt++;
          end else begin
            bin = lat / longint'(cur_width);
            if (bin >= BUCKETS) overflow_cnt++;
            else begin
              bin_count[bin]++;
              last_bin = int'(bin);
            end
          end
          if (latency_store.size() < CAPACITY) latency_store.push_back(lat);
        end
      end
      OP_QUERY: begin
        if (latency_store.size() != 0) begin
          srt = latency_store;
          srt.sort();
          r.median_latency  = rank_pick(srt, 50, 100);
          r.high_latency    = rank_pick(srt, P99_NUM, P99_DEN);
          r.extreme_latency = rank_pick(srt, P999_NUM, P999_DEN);
          r.stored_samples  = STORED_W'(latency_store.size());
          r.overflow_total  = overflow_cnt;
        end
      end
      OP_BUCKET_READ: r.bucket_value = bin_count[idx];
      default: ;
    endcase
    r.record_total = record_cnt;
    return r;
  endfunction

  // a word that can be read off at a glance: only rejected and record_total set
  function automatic res_t plain_word(bit rej, longint unsigned total);
    res_t r;
    r = '0;
    r.rejected = rej;
    r.record_total = total;
    return r;
  endfunction

  function automatic step_row_t item_row(bit [1:0] op, bit [63:0] recv, bit [63:0] send,
                                         bit [9:0] idx);
    step_row_t s;
    s = '{default: '0};
    s.op = op;
    s.recv = recv;
    s.send = send;
    s.idx = idx;
    return s;
  endfunction

  function automatic step_row_t fixed_row(bit [1:0] op, bit [63:0] recv, bit [63:0] send,
                                          bit [9:0] idx, res_t want);
    step_row_t s;
    s = item_row(op, recv, send, idx);
    s.fixed = 1'b1;
    s.want = want;
    return s;
  endfunction

  function automatic step_row_t width_row(bit [31:0] v);
    step_row_t s;
    s = '{default: '0};
    s.wr_width = 1'b1;
    s.width_val = v;
    return s;
  endfunction

  function automatic bit [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // width write only with the block idle: every word back, then a short pause
  task automatic write_width(bit [31:0] v);
    items_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_width = v;
  endtask

  // present one word, hold it until taken, then predict its result
  task automatic send_item(bit [1:0] op, bit [63:0] recv, bit [63:0] send, bit [9:0] idx,
                           bit fixed, res_t want);
    int gap;
    res_t r;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_if.valid         <= 1'b1;
    items_if.operation     <= op;
    items_if.received_time <= recv;
    items_if.send_time     <= send;
    items_if.bucket_index  <= idx;
    do @(posedge clk); while (!items_if.ready);
    r = histogram_result(op, recv, send, idx);
    pending_results.push_back(fixed ? want : r);
    case (op)
      OP_RECORD: begin
        n_records++;
        if (send < recv) n_rejects++;
      end
      OP_QUERY: n_queries++;
      OP_BUCKET_READ: n_reads++;
      default: ;
    endcase
  endtask

  // random word: mostly well-formed records shaped around the current width
  task automatic send_random(bit force_query);
    int pick, kind;
    bit [1:0] op;
    bit [63:0] lat, recv, send;
    bit [9:0] idx;
    pick = $urandom_range(0, 999);
    idx = 10'($urandom_range(0, 1023));
    recv = 0;
    send = 0;
    if (force_query || (pick < 10 && latency_store.size() < 200)) op = OP_QUERY;
    else if (pick < 70) begin
      op = OP_BUCKET_READ;
      if ($urandom_range(0, 1)) idx = 10'(last_bin);
    end else if (pick < 75) op = 2'd3;
    else op = OP_RECORD;
    kind = $urandom_range(0, 19);
    if (kind == 0) lat = 0;
    else if (kind < 15) begin
      if (cur_width == 0) lat = $urandom();
      else lat = longint'(cur_width) * $urandom_range(0, 1023) + $urandom() % cur_width;
    end else if (kind < 17) lat = longint'(cur_width) * 1024 + rand64() % 64'd100000;
    else lat = rand64();
    recv = $urandom_range(0, 2) == 0 ? 64'd0 : rand64();
    if (recv > ALL_ONES - lat) recv = ALL_ONES - lat;
    send = recv + lat;
    if (kind == 19) begin
      // unconstrained timestamps, rejected about half the time
      recv = rand64();
      send = rand64();
    end
    if (op != OP_RECORD && $urandom_range(0, 1)) begin
      // fields that the operation ignores still get toggled
      recv = rand64();
      send = rand64();
    end
    send_item(op, recv, send, idx, 1'b0, '0);
  endtask

  // result side: random stalls, one per word
  initial begin
    int stall;
    results_if.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        results_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      do @(posedge clk); while (!results_if.valid);
    end
  end

  // compare every accepted word with the oldest prediction
  always @(posedge clk) begin
    res_t w;
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no prediction pending");
        errors++;
      end else begin
        w = pending_results.pop_front();
        if (results_if.rejected !== w.rejected) begin
          $error("rejected: expected %0d, got %0d", w.rejected, results_if.rejected);
          errors++;
        end
        if (results_if.median_latency !== w.median_latency) begin
          $error("median_latency: expected %0d, got %0d", w.median_latency,
                 results_if.median_latency);
          errors++;
        end
        if (results_if.high_latency !== w.high_latency) begin
          $error("high_latency: expected %0d, got %0d", w.high_latency,
                 results_if.high_latency);
          errors++;
        end
        if (results_if.extreme_latency !== w.extreme_latency) begin
          $error("extreme_latency: expected %0d, got %0d", w.extreme_latency,
                 results_if.extreme_latency);
          errors++;
        end
        if (results_if.stored_samples !== w.stored_samples) begin
          $error("stored_samples: expected %0d, got %0d", w.stored_samples,
                 results_if.stored_samples);
          errors++;
        end
        if (results_if.overflow_total !== w.overflow_total) begin
          $error("overflow_total: expected %0d, got %0d", w.overflow_total,
                 results_if.overflow_total);
          errors++;
        end
        if (results_if.record_total !== w.record_total) begin
          $error("record_total: expected %0d, got %0d", w.record_total,
                 results_if.record_total);
          errors++;
        end
        if (results_if.bucket_value !== w.bucket_value) begin
          $error("bucket_value: expected %0d, got %0d", w.bucket_value,
                 results_if.bucket_value);
          errors++;
        end
      end
    end
  end

  // watchdog: full-store queries dominate, this is several times the slowest run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    bit [31:0] phase_width [6];
    step_row_t s;
    int wait_cycles;
    items_if.valid         = 1'b0;
    items_if.operation     = '0;
    items_if.received_time = '0;
    items_if.send_time     = '0;
    items_if.bucket_index  = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    overflow_cnt = 0;
    record_cnt = 0;
    cur_width = 5000;
    last_bin = 0;
    foreach (bin_count[i]) bin_count[i] = 0;

    // directed table, default width of 5000 after reset
    step_table.push_back(fixed_row(OP_QUERY, 0, 0, 0, plain_word(0, 0)));  // empty store
    step_table.push_back(fixed_row(OP_BUCKET_READ, 0, 0, 0, plain_word(0, 0)));
    step_table.push_back(fixed_row(OP_BUCKET_READ, 0, 0, 1023, plain_word(0, 0)));
    step_table.push_back(fixed_row(OP_RECORD, 5, 4, 0, plain_word(1, 0)));  // send before recv
    step_table.push_back(fixed_row(OP_RECORD, ALL_ONES, 0, 0, plain_word(1, 0)));
    step_table.push_back(item_row(OP_RECORD, 0, 0, 0));
    step_table.push_back(item_row(OP_RECORD, 0, 4999, 0));        // last ns of bucket 0
    step_table.push_back(item_row(OP_RECORD, 0, 5000, 0));
    step_table.push_back(item_row(OP_RECORD, 0, 5119999, 0));     // last bucket
    step_table.push_back(item_row(OP_RECORD, 0, 5120000, 0));     // first overflow
    step_table.push_back(item_row(OP_RECORD, 0, ALL_ONES, 1023));
    step_table.push_back(item_row(OP_RECORD, ALL_ONES, ALL_ONES, 1023));
    step_table.push_back(item_row(OP_RECORD, 100, 64'h8000_0000_0000_0007, 0));
    step_table.push_back(item_row(OP_QUERY, 0, 0, 0));
    step_table.push_back(item_row(OP_BUCKET_READ, 0, 0, 0));
    step_table.push_back(item_row(OP_BUCKET_READ, ALL_ONES, ALL_ONES, 1));
    step_table.push_back(item_row(OP_BUCKET_READ, 0, 0, 1023));
    step_table.push_back(fixed_row(2'd3, ALL_ONES, ALL_ONES, 1023, plain_word(0, 8)));
    // zero width sends every latency to overflow
    step_table.push_back(width_row(0));
    step_table.push_back(item_row(OP_RECORD, 0, 123, 0));
    step_table.push_back(item_row(OP_RECORD, 5, 5, 0));
    step_table.push_back(item_row(OP_QUERY, 0, 0, 0));
    step_table.push_back(item_row(OP_BUCKET_READ, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (step_table[i]) begin
      s = step_table[i];
      if (s.wr_width) write_width(s.width_val);
      else send_item(s.op, s.recv, s.send, s.idx, s.fixed, s.want);
    end

    // random phases, each under its own width, extremes among them
    phase_width[0] = 1;
    phase_width[1] = 32'hFFFF_FFFF;
    phase_width[2] = 37;
    phase_width[3] = $urandom_range(2, 100000);
    phase_width[4] = 1000;
    phase_width[5] = 5000;
    foreach (phase_width[p]) begin
      write_width(phase_width[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 48 == 0) calm = ($urandom_range(0, 3) == 0);
        send_random(k == PHASE_ITEMS - 1);
      end
    end

    items_if.valid <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      errors++;
    end
    repeat (80) @(posedge clk);

    $display("covered %0d records (%0d rejected), %0d queries, %0d bucket reads",
             n_records, n_rejects, n_queries, n_reads);
    $display("sample store ended holding %0d latencies, %0d in overflow",
             latency_store.size(), overflow_cnt);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
